// ===== src/bpm_pkg.sv =====
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types and constants for the bracket pair matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package bpm_pkg;

  // sizing
  localparam int STACK_DEPTH = 64;
  localparam int POS_W       = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // output queue sizing
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // bracket characters
  localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;

  // result kinds
  localparam logic RESULT_PAIR    = 1'b0;
  localparam logic RESULT_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    VERDICT_RIGHT       = 2'd0,
    VERDICT_WRONG_CLOSE = 2'd1,
    VERDICT_UNCLOSED    = 2'd2,
    VERDICT_OVERFLOW    = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       is_last;
  } bpm_in_t;

  typedef struct packed {
    logic             result_kind;
    logic [POS_W-1:0] open_position;
    logic [POS_W-1:0] close_position;
    logic [1:0]       verdict;
    logic [POS_W-1:0] error_position;
    logic             last_result;
  } bpm_out_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [POS_W-1:0] pos;
  } stack_entry_t;

  localparam int ENTRY_W = $bits(stack_entry_t);

  // results produced by one byte, first word before second
  typedef struct packed {
    logic     vld0;
    logic     vld1;
    bpm_out_t res0;
    bpm_out_t res1;
  } bpm_push_t;

endpackage

`default_nettype wire

// ===== src/bpm_ram.sv =====
// ----------------------------------------------------------------------------
// bpm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/bpm_core.sv =====
// ----------------------------------------------------------------------------
// bpm_core
// Stack control: push and pop against the stack RAM, failure tracking and
// verdict generation. The top entry for the next byte is prefetched.
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_core
  import bpm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire bpm_in_t   item_i,
  output bpm_push_t      push_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             failed_q, failed_d;
  logic [1:0]       code_q, code_d;
  logic [POS_W-1:0] fpos_q, fpos_d;
  logic             fwd_q, fwd_d;
  stack_entry_t     fwd_data_q, fwd_data_d;

  logic [ENTRY_W-1:0] rdata;
  logic [ADDR_W-1:0]  raddr;
  logic [CNT_W-1:0]   count_dec;
  stack_entry_t       top;
  stack_entry_t       push_entry;

  logic      is_open, is_close;
  kind_e     open_kind, close_kind;
  logic      empty, full, active;
  logic      do_push, do_pop, fail_ovf, fail_close, finish;
  logic      failed_n;
  logic [1:0] code_n;
  logic [POS_W-1:0] fpos_n;
  logic [CNT_W-1:0] count_after;
  bpm_out_t  pair_res, verdict_res;

  // decode the byte
  always_comb begin
    is_open    = 1'b0;
    is_close   = 1'b0;
    open_kind  = KIND_ROUND;
    close_kind = KIND_ROUND;
    unique case (item_i.symbol)
      CHAR_OPEN_ROUND: begin
        is_open = 1'b1;
        open_kind = KIND_ROUND;
      end
      CHAR_OPEN_SQUARE: begin
        is_open = 1'b1;
        open_kind = KIND_SQUARE;
      end
      CHAR_OPEN_CURLY: begin
        is_open = 1'b1;
        open_kind = KIND_CURLY;
      end
      CHAR_CLOSE_ROUND: begin
        is_close = 1'b1;
        close_kind = KIND_ROUND;
      end
      CHAR_CLOSE_SQUARE: begin
        is_close = 1'b1;
        close_kind = KIND_SQUARE;
      end
      CHAR_CLOSE_CURLY: begin
        is_close = 1'b1;
        close_kind = KIND_CURLY;
      end
      default: begin
        is_open  = 1'b0;
        is_close = 1'b0;
      end
    endcase
  end

  // a push in the previous cycle bypasses the ram read of the same entry
  assign top = fwd_q ? fwd_data_q : stack_entry_t'(rdata);

  assign empty  = (count_q == '0);
  assign full   = (count_q == CNT_W'(STACK_DEPTH));
  assign active = accept_i && !failed_q;
  assign finish = accept_i && item_i.is_last;

  assign do_push    = active && is_open && !full;
  assign fail_ovf   = active && is_open && full;
  assign do_pop     = active && is_close && !empty && (top.kind == close_kind);
  assign fail_close = active && is_close && !do_pop;

  assign push_entry.kind = open_kind;
  assign push_entry.pos  = pos_q;

  always_comb begin
    failed_n = failed_q;
    code_n   = code_q;
    fpos_n   = fpos_q;
    if (fail_ovf) begin
      failed_n = 1'b1;
      code_n   = VERDICT_OVERFLOW;
      fpos_n   = pos_q;
    end else if (fail_close) begin
      failed_n = 1'b1;
      code_n   = VERDICT_WRONG_CLOSE;
      fpos_n   = pos_q;
    end
  end

  always_comb begin
    count_after = count_q;
    if (do_push) begin
      count_after = count_q + 1'b1;
    end else if (do_pop) begin
      count_after = count_q - 1'b1;
    end
  end

  // result words
  always_comb begin
    pair_res                = '0;
    pair_res.result_kind    = RESULT_PAIR;
    pair_res.open_position  = top.pos;
    pair_res.close_position = pos_q;

    verdict_res             = '0;
    verdict_res.result_kind = RESULT_VERDICT;
    verdict_res.last_result = 1'b1;
    if (failed_n) begin
      verdict_res.verdict        = code_n;
      verdict_res.error_position = fpos_n;
    end else if (count_after != '0) begin
      verdict_res.verdict        = VERDICT_UNCLOSED;
      verdict_res.error_position = pos_q;
    end else begin
      verdict_res.verdict        = VERDICT_RIGHT;
      verdict_res.error_position = '0;
    end
  end

  assign push_o.vld0 = do_pop || finish;
  assign push_o.vld1 = do_pop && finish;
  assign push_o.res0 = do_pop ? pair_res : verdict_res;
  assign push_o.res1 = verdict_res;

  // next state
  always_comb begin
    count_d    = count_after;
    pos_d      = pos_q;
    failed_d   = failed_n;
    code_d     = code_n;
    fpos_d     = fpos_n;
    fwd_d      = do_push;
    fwd_data_d = push_entry;
    if (accept_i && (pos_q != '1)) begin
      pos_d = pos_q + 1'b1;
    end
    if (finish) begin
      count_d  = '0;
      pos_d    = '0;
      failed_d = 1'b0;
      code_d   = VERDICT_RIGHT;
      fpos_d   = '0;
    end
  end

  // prefetch the entry that will be on top for the next byte
  assign count_dec = count_d - 1'b1;
  assign raddr     = count_dec[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      pos_q    <= '0;
      failed_q <= 1'b0;
      code_q   <= VERDICT_RIGHT;
      fpos_q   <= '0;
      fwd_q    <= 1'b0;
    end else begin
      count_q  <= count_d;
      pos_q    <= pos_d;
      failed_q <= failed_d;
      code_q   <= code_d;
      fpos_q   <= fpos_d;
      fwd_q    <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= fwd_data_d;
  end

  bpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (push_entry),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (count_q == '0) && (pos_q == '0) && !failed_q)
    else $error("state not cleared after last byte");

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (failed_q && !finish) |=> failed_q)
    else $error("failure flag dropped before last byte");

  a_fwd_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> $past(do_push))
    else $error("forward set without a push");
`endif

endmodule

`default_nettype wire

// ===== src/bpm_out_queue.sv =====
// ----------------------------------------------------------------------------
// bpm_out_queue
// Small result queue: takes up to two words per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_out_queue
  import bpm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire bpm_push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output bpm_out_t       out_data_o
);

  bpm_out_t           mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic               pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  // room for the two words one byte can produce
  assign room_o      = (cnt_q <= Q_CNT_W'(Q_DEPTH - 2));
  assign wr_ptr_nxt  = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + Q_PTR_W'(push_i.vld0) + Q_PTR_W'(push_i.vld1);
    rd_ptr_d = rd_ptr_q + Q_PTR_W'(pop);
    cnt_d    = cnt_q + Q_CNT_W'(push_i.vld0) + Q_CNT_W'(push_i.vld1) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.vld1) begin
      mem_q[wr_ptr_nxt] <= push_i.res1;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count above depth");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.vld1 |-> push_i.vld0)
    else $error("second word without first");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.vld0 |-> (cnt_q <= Q_CNT_W'(Q_DEPTH - 2)))
    else $error("write into a full queue");
`endif

endmodule

`default_nettype wire

// ===== src/bracket_pair_matcher.sv =====
// ----------------------------------------------------------------------------
// bracket_pair_matcher
// Streams text bytes, matches (), [] and {} pairs with a stack in RAM and
// reports each matched pair plus a final verdict per text.
// ----------------------------------------------------------------------------
// a result word is formed combinationally when the byte is accepted and offered from the output queue
// throughput: one byte per cycle while in_ready_o is high; the stack top is
//   prefetched from the stack RAM for the next byte, a push in the previous cycle is forwarded
// in_ready_o drops while more than two result words wait in the queue
// reset: asynchronous, clears stack count, position, failure state and the
//   queue; stack RAM is not cleared, entries above the count are never used
`default_nettype none

module bracket_pair_matcher
  import bpm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire bpm_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output bpm_out_t     out_data_o
);

  logic      accept;
  bpm_push_t push;

  assign accept = in_valid_i && in_ready_o;

  bpm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .push_o   (push)
  );

  bpm_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== sim/bracket_pair_matcher_checker.sv =====
// ----------------------------------------------------------------------------
// bracket_pair_matcher_checker
// Watches both channels of the bracket pair matcher, tracks the open bracket
// stack, position and failure state of each text, and compares every result
// word with the oldest word still expected.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_pair_matcher_checker
  import bpm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  bpm_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  bpm_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o,
  output int       pair_count_o,
  output int       text_count_o,
  output int       bad_text_count_o
);

  localparam int REPORT_LIMIT = 10;

  stack_entry_t     open_stack_m [STACK_DEPTH];
  int unsigned      depth_m;
  logic [POS_W-1:0] pos_m;
  logic             failed_m;
  verdict_e         fail_code_m;
  logic [POS_W-1:0] fail_pos_m;

  bpm_out_t expected_q [$];
  int       mismatches = 0;
  int       pairs      = 0;
  int       texts      = 0;
  int       bad_texts  = 0;

  task automatic fail_text(input verdict_e code, input logic [POS_W-1:0] where);
    failed_m    = 1'b1;
    fail_code_m = code;
    fail_pos_m  = where;
  endtask

  // predicts the words caused by one text byte
  task automatic match_byte(input bpm_in_t w);
    logic [POS_W-1:0] here;
    logic             is_open;
    logic             is_close;
    kind_e            k;
    bpm_out_t         r;
    here     = pos_m;
    is_open  = 1'b0;
    is_close = 1'b0;
    k        = KIND_ROUND;
    if (pos_m != '1) pos_m = pos_m + 1'b1;
    case (w.symbol)
      CHAR_OPEN_ROUND:   begin is_open  = 1'b1; k = KIND_ROUND;  end
      CHAR_OPEN_SQUARE:  begin is_open  = 1'b1; k = KIND_SQUARE; end
      CHAR_OPEN_CURLY:   begin is_open  = 1'b1; k = KIND_CURLY;  end
      CHAR_CLOSE_ROUND:  begin is_close = 1'b1; k = KIND_ROUND;  end
      CHAR_CLOSE_SQUARE: begin is_close = 1'b1; k = KIND_SQUARE; end
      CHAR_CLOSE_CURLY:  begin is_close = 1'b1; k = KIND_CURLY;  end
      default: ;
    endcase
    if (!failed_m) begin
      if (is_open) begin
        if (depth_m >= STACK_DEPTH) begin
          fail_text(VERDICT_OVERFLOW, here);
        end else begin
          open_stack_m[depth_m].kind = k;
          open_stack_m[depth_m].pos  = here;
          depth_m++;
        end
      end else if (is_close) begin
        if (depth_m == 0 || open_stack_m[depth_m-1].kind != k) begin
          fail_text(VERDICT_WRONG_CLOSE, here);
        end else begin
          depth_m--;
          r                = '0;
          r.result_kind    = RESULT_PAIR;
          r.open_position  = open_stack_m[depth_m].pos;
          r.close_position = here;
          expected_q.push_back(r);
          pairs++;
        end
      end
    end
    if (w.is_last) begin
      r             = '0;
      r.result_kind = RESULT_VERDICT;
      r.last_result = 1'b1;
      if (failed_m) begin
        r.verdict        = fail_code_m;
        r.error_position = fail_pos_m;
      end else if (depth_m != 0) begin
        r.verdict        = VERDICT_UNCLOSED;
        r.error_position = here;
      end
      expected_q.push_back(r);
      texts++;
      if (r.verdict != VERDICT_RIGHT) bad_texts++;
      depth_m     = 0;
      pos_m       = '0;
      failed_m    = 1'b0;
      fail_code_m = VERDICT_RIGHT;
      fail_pos_m  = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bpm_out_t want;
    if (!rst_ni) begin
      depth_m     = 0;
      pos_m       = '0;
      failed_m    = 1'b0;
      fail_code_m = VERDICT_RIGHT;
      fail_pos_m  = '0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected word kind %0d open %0d close %0d verdict %0d err %0d last %0d",
                     $realtime, out_data_i.result_kind, out_data_i.open_position,
                     out_data_i.close_position, out_data_i.verdict,
                     out_data_i.error_position, out_data_i.last_result);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: word mismatch", $realtime);
              $display("  expected kind %0d open %0d close %0d verdict %0d err %0d last %0d",
                       want.result_kind, want.open_position, want.close_position,
                       want.verdict, want.error_position, want.last_result);
              $display("  actual   kind %0d open %0d close %0d verdict %0d err %0d last %0d",
                       out_data_i.result_kind, out_data_i.open_position,
                       out_data_i.close_position, out_data_i.verdict,
                       out_data_i.error_position, out_data_i.last_result);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) match_byte(in_data_i);
    end
    fail_count_o     <= mismatches;
    pending_o        <= expected_q.size();
    pair_count_o     <= pairs;
    text_count_o     <= texts;
    bad_text_count_o <= bad_texts;
  end

endmodule

// ===== sim/bracket_pair_matcher_tb.sv =====
// ----------------------------------------------------------------------------
// bracket_pair_matcher_tb
// Feeds texts to the bracket pair matcher: short directed texts, stacks filled
// to the limit and past it, and random texts that are mostly well nested with
// some broken ones and noise. Both sides idle at random; a checker predicts
// and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_pair_matcher_tb;
  import bpm_pkg::*;

  localparam int RANDOM_BYTES = 1600;
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  bpm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bpm_out_t out_data;

  int fail_count;
  int pending;
  int pair_count;
  int text_count;
  int bad_text_count;

  int         cycle_count = 0;
  int         bytes_sent  = 0;
  bit         steady      = 1'b0;
  logic [7:0] text_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bracket_pair_matcher dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  bracket_pair_matcher_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .pair_count_o     (pair_count),
    .text_count_o     (text_count),
    .bad_text_count_o (bad_text_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] open_char(input kind_e k);
    case (k)
      KIND_ROUND:  return CHAR_OPEN_ROUND;
      KIND_SQUARE: return CHAR_OPEN_SQUARE;
      default:     return CHAR_OPEN_CURLY;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input kind_e k);
    case (k)
      KIND_ROUND:  return CHAR_CLOSE_ROUND;
      KIND_SQUARE: return CHAR_CLOSE_SQUARE;
      default:     return CHAR_CLOSE_CURLY;
    endcase
  endfunction

  function automatic kind_e any_kind();
    return kind_e'($urandom_range(0, 2));
  endfunction

  // any byte that is not a bracket
  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    forever begin
      b = 8'($urandom_range(0, 255));
      case (b)
        CHAR_OPEN_ROUND, CHAR_OPEN_SQUARE, CHAR_OPEN_CURLY,
        CHAR_CLOSE_ROUND, CHAR_CLOSE_SQUARE, CHAR_CLOSE_CURLY: ;
        default: return b;
      endcase
    end
  endfunction

  // receiver: random stall before each word, valid never awaited while low
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // valid stays high from one word to the next when there is no gap
  task automatic send_byte(input logic [7:0] sym, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {sym, last};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic build_random_text();
    kind_e opens [$];
    kind_e k;
    int    style;
    int    len;
    int    cap;
    int    cut;
    int    i;
    text_q.delete();
    style = $urandom_range(0, 19);
    len   = $urandom_range(1, 24);
    cap   = $urandom_range(1, 8);
    if (style >= 17 && style <= 18) begin
      // noise, brackets dense
      for (i = 0; i < len; i++)
        if ($urandom_range(0, 1) == 1)
          text_q.push_back($urandom_range(0, 1) ? open_char(any_kind())
                                                : close_char(any_kind()));
        else
          text_q.push_back(8'($urandom_range(0, 255)));
    end else if (style == 19) begin
      // deep nesting around the stack limit
      cap = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4);
      for (i = 0; i < cap; i++) begin
        k = any_kind();
        opens.push_back(k);
        text_q.push_back(open_char(k));
        if ($urandom_range(0, 7) == 0) text_q.push_back(filler_byte());
      end
      while (opens.size() > 0) text_q.push_back(close_char(opens.pop_back()));
    end else begin
      cut = (style >= 12 && style <= 14) ? $urandom_range(0, len - 1) : -1;
      for (i = 0; i < len; i++) begin
        if (i == cut) begin
          if (opens.size() == 0) k = any_kind();
          else k = kind_e'((opens[$] + $urandom_range(1, 2)) % 3);
          text_q.push_back(close_char(k));
        end else begin
          case ($urandom_range(0, 2))
            0: if (opens.size() < cap) begin
              k = any_kind();
              opens.push_back(k);
              text_q.push_back(open_char(k));
            end
            1: if (opens.size() > 0) text_q.push_back(close_char(opens.pop_back()));
            default: text_q.push_back(filler_byte());
          endcase
        end
      end
      if (style >= 15) begin
        if (opens.size() == 0) text_q.push_back(open_char(any_kind()));
        if ($urandom_range(0, 1) == 1) text_q.push_back(filler_byte());
      end else begin
        while (opens.size() > 0) text_q.push_back(close_char(opens.pop_back()));
      end
    end
    if (text_q.size() == 0) text_q.push_back(filler_byte());
  endtask

  initial begin
    int base;
    int i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed texts
    text_q = '{CHAR_OPEN_ROUND, CHAR_CLOSE_ROUND};
    send_text();
    text_q = '{CHAR_OPEN_SQUARE, CHAR_OPEN_CURLY, CHAR_CLOSE_CURLY, CHAR_CLOSE_SQUARE, 8'h00};
    send_text();
    text_q = '{CHAR_OPEN_ROUND, CHAR_CLOSE_SQUARE, CHAR_OPEN_ROUND, 8'hFF};
    send_text();
    text_q = '{CHAR_CLOSE_CURLY};
    send_text();
    text_q = '{CHAR_OPEN_CURLY, 8'h61};
    send_text();
    text_q = '{CHAR_OPEN_SQUARE};
    send_text();
    text_q = '{8'hFF};
    send_text();
    text_q = '{CHAR_CLOSE_ROUND, CHAR_OPEN_CURLY, CHAR_CLOSE_CURLY};
    send_text();

    // stack filled exactly, then one open past the limit
    text_q.delete();
    for (i = 0; i < STACK_DEPTH; i++) text_q.push_back(open_char(kind_e'(i % 3)));
    for (i = STACK_DEPTH - 1; i >= 0; i--) text_q.push_back(close_char(kind_e'(i % 3)));
    send_text();
    text_q.delete();
    for (i = 0; i <= STACK_DEPTH; i++) text_q.push_back(open_char(kind_e'(i % 3)));
    text_q.push_back(CHAR_CLOSE_ROUND);
    text_q.push_back(filler_byte());
    send_text();
    drain();

    // random texts
    base = bytes_sent;
    while (bytes_sent - base < RANDOM_BYTES) begin
      steady = ($urandom_range(0, 5) == 0);
      build_random_text();
      send_text();
    end
    steady = 1'b0;
    drain();
    repeat (20) @(posedge clk);

    $display("sent %0d bytes in %0d texts, %0d of them failed; %0d pairs matched",
             bytes_sent, text_count, bad_text_count, pair_count);
    $display("covered full and overflowing stacks, broken closes and unclosed texts");
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
